// ===== rtl/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg
// Types, codes and the cp1252 0x80..0x9F table shared by the transcoder files.
// ----------------------------------------------------------------------------
package cst_pkg;

    localparam logic [2:0] ENC_UTF8   = 3'd0;
    localparam logic [2:0] ENC_ASCII  = 3'd1;
    localparam logic [2:0] ENC_LATIN1 = 3'd2;
    localparam logic [2:0] ENC_CP1252 = 3'd3;
    localparam logic [2:0] ENC_UCS4   = 3'd4;

    localparam logic [1:0] KIND_DATA       = 2'd0;
    localparam logic [1:0] KIND_ILLEGAL    = 2'd1;
    localparam logic [1:0] KIND_INCOMPLETE = 2'd2;
    localparam logic [1:0] KIND_DROPPED    = 2'd3;

    localparam logic [1:0] CFG_SOURCE  = 2'd0;
    localparam logic [1:0] CFG_TARGET  = 2'd1;
    localparam logic [1:0] CFG_TRANSLIT = 2'd2;

    localparam int CFG_DATA_W = 3;
    localparam int QDEPTH     = 4;
    localparam int QAW        = $clog2(QDEPTH);

    localparam logic [7:0] QMARK = 8'h3F;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  kind;
        logic        last_of_run;
        logic [31:0] substitution_count;
    } out_item_t;

    // one step's results, queued between front and back
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      kind;
        logic [1:0]      last_idx;
        logic [31:0]     count;
    } rec_t;

    function automatic logic [15:0] cp1252_high(input logic [4:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:  v = 16'h20AC;
            5'd1:  v = 16'h0081;
            5'd2:  v = 16'h201A;
            5'd3:  v = 16'h0192;
            5'd4:  v = 16'h201E;
            5'd5:  v = 16'h2026;
            5'd6:  v = 16'h2020;
            5'd7:  v = 16'h2021;
            5'd8:  v = 16'h02C6;
            5'd9:  v = 16'h2030;
            5'd10: v = 16'h0160;
            5'd11: v = 16'h2039;
            5'd12: v = 16'h0152;
            5'd13: v = 16'h008D;
            5'd14: v = 16'h017D;
            5'd15: v = 16'h008F;
            5'd16: v = 16'h0090;
            5'd17: v = 16'h2018;
            5'd18: v = 16'h2019;
            5'd19: v = 16'h201C;
            5'd20: v = 16'h201D;
            5'd21: v = 16'h2022;
            5'd22: v = 16'h2013;
            5'd23: v = 16'h2014;
            5'd24: v = 16'h02DC;
            5'd25: v = 16'h2122;
            5'd26: v = 16'h0161;
            5'd27: v = 16'h203A;
            5'd28: v = 16'h0153;
            5'd29: v = 16'h009D;
            5'd30: v = 16'h017E;
            5'd31: v = 16'h0178;
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/cst_front.sv =====
// ----------------------------------------------------------------------------
// cst_front
// Decodes source bytes into code points, encodes them for the target and
// pushes one record per step that has results.
// ----------------------------------------------------------------------------
module cst_front #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [2:0]        cfg_data,
    input  logic              accept,
    input  cst_pkg::in_item_t in_item,
    output logic              push,
    output cst_pkg::rec_t     push_rec
);
    import cst_pkg::*;

    logic [2:0]             src_reg, tgt_reg;
    logic                   translit_reg;
    logic [31:0]            acc_reg, acc_next;
    logic [2:0]             seen_reg, seen_next;
    logic [2:0]             exp_reg, exp_next;
    logic                   badc_reg, badc_next;
    logic                   drain_reg, drain_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next, cnt_inc;

    logic [7:0]  b;
    logic        eob;
    logic        have;
    logic [31:0] cp;
    logic [1:0]  err;
    logic        err_on;
    logic [31:0] acc_v;
    logic [2:0]  seen_v;
    logic        bc_v;
    logic [3:0][7:0] enc_bytes;
    logic [2:0]  enc_n;
    logic        enc_bad_tgt;
    logic        found;
    logic [4:0]  found_idx;
    logic [31:0] view_now, view_inc;

    assign b   = in_item.in_byte;
    assign eob = in_item.end_of_buffer;

    // saturated 32-bit views of the counter
    generate
        if (COUNT_WIDTH > 32) begin : g_wide
            assign view_now = (|cnt_reg[COUNT_WIDTH-1:32]) ? 32'hFFFF_FFFF : cnt_reg[31:0];
            assign view_inc = (|cnt_inc[COUNT_WIDTH-1:32]) ? 32'hFFFF_FFFF : cnt_inc[31:0];
        end else if (COUNT_WIDTH == 32) begin : g_exact
            assign view_now = cnt_reg;
            assign view_inc = cnt_inc;
        end else begin : g_narrow
            assign view_now = {{(32-COUNT_WIDTH){1'b0}}, cnt_reg};
            assign view_inc = {{(32-COUNT_WIDTH){1'b0}}, cnt_inc};
        end
    endgenerate

    // cp1252 reverse lookup
    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = 0; i < 32; i++) begin
            if ({16'h0000, cp1252_high(5'(i))} == cp) begin
                found     = 1'b1;
                found_idx = 5'(i);
            end
        end
    end

    // target encoder
    always_comb begin
        enc_bytes   = '0;
        enc_n       = 3'd0;
        enc_bad_tgt = 1'b0;
        case (tgt_reg)
            ENC_UTF8: begin
                if (cp < 32'h80) begin
                    enc_bytes[0] = cp[7:0];
                    enc_n        = 3'd1;
                end else if (cp < 32'h800) begin
                    enc_bytes[0] = {3'b110, cp[10:6]};
                    enc_bytes[1] = {2'b10, cp[5:0]};
                    enc_n        = 3'd2;
                end else if (cp < 32'h10000) begin
                    if (!(cp >= 32'hD800 && cp <= 32'hDFFF)) begin
                        enc_bytes[0] = {4'b1110, cp[15:12]};
                        enc_bytes[1] = {2'b10, cp[11:6]};
                        enc_bytes[2] = {2'b10, cp[5:0]};
                        enc_n        = 3'd3;
                    end
                end else if (cp <= 32'h10FFFF) begin
                    enc_bytes[0] = {5'b11110, cp[20:18]};
                    enc_bytes[1] = {2'b10, cp[17:12]};
                    enc_bytes[2] = {2'b10, cp[11:6]};
                    enc_bytes[3] = {2'b10, cp[5:0]};
                    enc_n        = 3'd4;
                end
            end
            ENC_ASCII: begin
                if (cp <= 32'h7F) begin
                    enc_bytes[0] = cp[7:0];
                    enc_n        = 3'd1;
                end
            end
            ENC_LATIN1: begin
                if (cp <= 32'hFF) begin
                    enc_bytes[0] = cp[7:0];
                    enc_n        = 3'd1;
                end
            end
            ENC_CP1252: begin
                if (cp < 32'h80 || (cp >= 32'hA0 && cp <= 32'hFF)) begin
                    enc_bytes[0] = cp[7:0];
                    enc_n        = 3'd1;
                end else if (found) begin
                    enc_bytes[0] = {3'b100, found_idx};
                    enc_n        = 3'd1;
                end
            end
            ENC_UCS4: begin
                enc_bytes = cp;
                enc_n     = 3'd4;
            end
            default: begin
                enc_bad_tgt = 1'b1;
            end
        endcase
    end

    // source decoder and step result
    always_comb begin
        acc_next   = acc_reg;
        seen_next  = seen_reg;
        exp_next   = exp_reg;
        badc_next  = badc_reg;
        drain_next = drain_reg;
        cnt_inc    = cnt_reg;
        have       = 1'b0;
        cp         = '0;
        err        = KIND_DATA;
        err_on     = 1'b0;
        acc_v      = acc_reg;
        seen_v     = seen_reg + 3'd1;
        bc_v       = badc_reg;
        push       = 1'b0;
        push_rec   = '0;

        if (drain_reg) begin
            if (eob) begin
                drain_next     = 1'b0;
                push           = accept;
                push_rec.kind  = KIND_DROPPED;
                push_rec.count = view_now;
            end
        end else begin
            case (src_reg)
                ENC_UTF8: begin
                    if (seen_reg == 3'd0) begin
                        if (b < 8'h80) begin
                            cp   = {24'h0, b};
                            have = 1'b1;
                        end else if (b[7:5] == 3'b110) begin
                            exp_next  = 3'd2;
                            acc_next  = {27'h0, b[4:0]};
                            seen_next = 3'd1;
                            badc_next = 1'b0;
                        end else if (b[7:4] == 4'b1110) begin
                            exp_next  = 3'd3;
                            acc_next  = {28'h0, b[3:0]};
                            seen_next = 3'd1;
                            badc_next = 1'b0;
                        end else if (b[7:3] == 5'b11110) begin
                            exp_next  = 3'd4;
                            acc_next  = {29'h0, b[2:0]};
                            seen_next = 3'd1;
                            badc_next = 1'b0;
                        end else begin
                            err = KIND_ILLEGAL;
                        end
                    end else begin
                        bc_v  = badc_reg | (b[7:6] != 2'b10);
                        acc_v = {acc_reg[25:0], b[5:0]};
                        if (seen_v >= exp_reg) begin
                            acc_next  = '0;
                            seen_next = '0;
                            exp_next  = '0;
                            badc_next = 1'b0;
                            if (bc_v) begin
                                err = KIND_ILLEGAL;
                            end else if (exp_reg == 3'd2 && acc_v < 32'h80) begin
                                err = KIND_ILLEGAL;
                            end else if (exp_reg == 3'd3 && (acc_v < 32'h800 ||
                                         (acc_v >= 32'hD800 && acc_v <= 32'hDFFF))) begin
                                err = KIND_ILLEGAL;
                            end else if (exp_reg == 3'd4 && (acc_v < 32'h10000 ||
                                         acc_v > 32'h10FFFF)) begin
                                err = KIND_ILLEGAL;
                            end else begin
                                cp   = acc_v;
                                have = 1'b1;
                            end
                        end else begin
                            acc_next  = acc_v;
                            seen_next = seen_v;
                            badc_next = bc_v;
                        end
                    end
                end
                ENC_ASCII: begin
                    if (b > 8'h7F) begin
                        err = KIND_ILLEGAL;
                    end else begin
                        cp   = {24'h0, b};
                        have = 1'b1;
                    end
                end
                ENC_LATIN1: begin
                    cp   = {24'h0, b};
                    have = 1'b1;
                end
                ENC_CP1252: begin
                    cp   = (b[7:5] == 3'b100) ? {16'h0, cp1252_high(b[4:0])} : {24'h0, b};
                    have = 1'b1;
                end
                ENC_UCS4: begin
                    acc_v[{seen_reg[1:0], 3'b000} +: 8] =
                        acc_reg[{seen_reg[1:0], 3'b000} +: 8] | b;
                    if (seen_v >= 3'd4) begin
                        cp        = acc_v;
                        have      = 1'b1;
                        acc_next  = '0;
                        seen_next = '0;
                        exp_next  = '0;
                        badc_next = 1'b0;
                    end else begin
                        acc_next  = acc_v;
                        seen_next = seen_v;
                    end
                end
                default: begin
                    err = KIND_ILLEGAL;
                end
            endcase

            if (!have && err == KIND_DATA && eob && seen_next != 3'd0) begin
                err = KIND_INCOMPLETE;
            end

            if (have) begin
                if (enc_bad_tgt) begin
                    err = KIND_ILLEGAL;
                end else if (enc_n == 3'd0) begin
                    if (translit_reg) begin
                        if (cnt_reg != '1) begin
                            cnt_inc = cnt_reg + 1'b1;
                        end
                    end else begin
                        err = KIND_ILLEGAL;
                    end
                end
            end

            err_on = (err != KIND_DATA);
            if (err_on) begin
                acc_next       = '0;
                seen_next      = '0;
                exp_next       = '0;
                badc_next      = 1'b0;
                drain_next     = !eob;
                push           = accept;
                push_rec.kind  = err;
                push_rec.count = view_now;
            end else if (have) begin
                push           = accept;
                push_rec.kind  = KIND_DATA;
                push_rec.count = view_inc;
                if (enc_n == 3'd0) begin
                    push_rec.bytes[0] = QMARK;
                    push_rec.last_idx = 2'd0;
                end else begin
                    push_rec.bytes    = enc_bytes;
                    push_rec.last_idx = 2'(enc_n - 3'd1);
                end
            end
        end

        cnt_next = eob ? '0 : cnt_inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_reg      <= ENC_UTF8;
            tgt_reg      <= ENC_UTF8;
            translit_reg <= 1'b0;
            acc_reg      <= '0;
            seen_reg     <= '0;
            exp_reg      <= '0;
            badc_reg     <= 1'b0;
            drain_reg    <= 1'b0;
            cnt_reg      <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SOURCE:   src_reg      <= cfg_data;
                CFG_TARGET:   tgt_reg      <= cfg_data;
                CFG_TRANSLIT: translit_reg <= cfg_data[0];
                default: ;
            endcase
            if (cfg_index == CFG_SOURCE || cfg_index == CFG_TARGET ||
                cfg_index == CFG_TRANSLIT) begin
                acc_reg  <= '0;
                seen_reg <= '0;
                exp_reg  <= '0;
                badc_reg <= 1'b0;
            end
        end else if (accept) begin
            acc_reg   <= acc_next;
            seen_reg  <= seen_next;
            exp_reg   <= exp_next;
            badc_reg  <= badc_next;
            drain_reg <= drain_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== rtl/cst_queue.sv =====
// ----------------------------------------------------------------------------
// cst_queue
// Short record queue between the decode front and the output back end.
// ----------------------------------------------------------------------------
module cst_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  cst_pkg::rec_t push_rec,
    input  logic          pop,
    output cst_pkg::rec_t head_rec,
    output logic          not_empty,
    output logic          full
);
    import cst_pkg::*;

    rec_t           mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   cnt_reg;

    assign head_rec  = mem_reg[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == (QAW+1)'(QDEPTH));

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// ===== rtl/cst_back.sv =====
// ----------------------------------------------------------------------------
// cst_back
// Walks the head record and hands out its results one item per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module cst_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  cst_pkg::rec_t      head_rec,
    input  logic               not_empty,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output cst_pkg::out_item_t m_data
);
    import cst_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       last;

    assign last    = (idx_reg == head_rec.last_idx);
    assign m_valid = not_empty;
    assign pop     = m_valid && m_ready && last;

    always_comb begin
        m_data.out_byte           = head_rec.bytes[idx_reg];
        m_data.kind               = head_rec.kind;
        m_data.last_of_run        = last;
        m_data.substitution_count = head_rec.count;
    end

    always_comb begin
        idx_next = idx_reg;
        if (m_valid && m_ready) begin
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

endmodule

// ===== rtl/charset_transcoder.sv =====
// ----------------------------------------------------------------------------
// charset_transcoder
// Transcodes a byte stream between utf-8, ascii, latin-1, cp1252 and ucs-4.
// ----------------------------------------------------------------------------
// s_ channel: one source byte per item with an end-of-buffer flag.
// m_ channel: encoded bytes and status items (illegal, incomplete, end after
//   drop); last_of_run marks the final result of one source byte.
// cfg_ port: write-only registers; the user must write them only while the block is
//   idle, which the block itself does not enforce.
// Throughput: one source byte per cycle while s_ready is high; results go through
//   a 4-entry record queue between the decoder and the output stage, which absorbs
//   the bursts of a byte that yields more than one output byte.
// Stalls: while m_ready is low the queue fills; s_ready falls when it is full
//   and no item is lost.
// Reset: clears the partial character, drop mode, the substitution count,
//   the queue and the registers (utf-8 to utf-8, transliteration off).
// ----------------------------------------------------------------------------
module charset_transcoder #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [2:0]         cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  cst_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output cst_pkg::out_item_t m_data
);
    import cst_pkg::*;

    logic accept;
    logic push, pop, not_empty, full;
    rec_t push_rec, head_rec;

    assign s_ready = !full;
    assign accept  = s_valid && s_ready;

    cst_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .accept   (accept),
        .in_item  (s_data),
        .push     (push),
        .push_rec (push_rec)
    );

    cst_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .not_empty(not_empty),
        .full     (full)
    );

    cst_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_rec (head_rec),
        .not_empty(not_empty),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

`ifndef NO_ASSERTIONS
    // status items stand alone
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind != KIND_DATA |-> m_data.last_of_run && m_data.out_byte == 8'h00)
        else $error("status item not last or carries data");

    // a full queue always has something to offer
    a_full_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output");

    // nothing on the output right after reset
    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_valid)
        else $error("output valid after reset");
`endif

endmodule

// ===== tb/tb_charset_transcoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_charset_transcoder
// Checks the transcoder against a byte-level predictor of its decode/encode.
// A directed burst walks the utf-8 corner cases (longest forms, overlong,
// surrogate, out-of-range, bad lead and continuation, cut-off characters,
// drop to the end mark). Then register phases run every source and target
// code, unknown codes and transliteration with mostly well-formed random
// characters plus stray bytes. Both sides stall at random, and one long
// output hold fills the block so that it stalls its input.
// ----------------------------------------------------------------------------
module tb_charset_transcoder;
    import cst_pkg::*;

    localparam int CNT_W = 32;
    localparam longint unsigned CNT_MAX = (64'd1 << CNT_W) - 64'd1;
    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam logic [2:0] ENC_UNKNOWN = 3'd7;

    localparam logic [0:31][15:0] CP1252_HI = {
        16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
        16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
    };

    class transcode_tracker;
        bit [2:0]          src_enc;
        bit [2:0]          tgt_enc;
        bit                translit;
        bit [31:0]         acc;
        int unsigned       seen;
        int unsigned       want;
        bit                bad_cont;
        bit                draining;
        longint unsigned   subst;
        out_item_t         owed_items[$];
        int                fails;

        function void clear_partial();
            acc = 0;
            seen = 0;
            want = 0;
            bad_cont = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [2:0] val);
            case (idx)
                CFG_SOURCE: src_enc = val;
                CFG_TARGET: tgt_enc = val;
                CFG_TRANSLIT: translit = val[0];
                default: return;
            endcase
            clear_partial();
        endfunction

        function bit [31:0] count_view();
            return (subst > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : subst[31:0];
        endfunction

        // byte count 1..4, 0 if not writable, -1 for an unknown encoding
        function int encode_as(bit [2:0] enc, bit [31:0] cp, output bit [3:0][7:0] b);
            b = '0;
            case (enc)
                ENC_UTF8: begin
                    if (cp < 32'h80) begin
                        b[0] = cp[7:0];
                        return 1;
                    end
                    if (cp < 32'h800) begin
                        b[0] = {3'b110, cp[10:6]};
                        b[1] = {2'b10, cp[5:0]};
                        return 2;
                    end
                    if (cp < 32'h10000) begin
                        if (cp >= 32'hD800 && cp <= 32'hDFFF) return 0;
                        b[0] = {4'b1110, cp[15:12]};
                        b[1] = {2'b10, cp[11:6]};
                        b[2] = {2'b10, cp[5:0]};
                        return 3;
                    end
                    if (cp <= 32'h10FFFF) begin
                        b[0] = {5'b11110, cp[20:18]};
                        b[1] = {2'b10, cp[17:12]};
                        b[2] = {2'b10, cp[11:6]};
                        b[3] = {2'b10, cp[5:0]};
                        return 4;
                    end
                    return 0;
                end
                ENC_ASCII: begin
                    if (cp > 32'h7F) return 0;
                    b[0] = cp[7:0];
                    return 1;
                end
                ENC_LATIN1: begin
                    if (cp > 32'hFF) return 0;
                    b[0] = cp[7:0];
                    return 1;
                end
                ENC_CP1252: begin
                    if (cp < 32'h80 || (cp >= 32'hA0 && cp <= 32'hFF)) begin
                        b[0] = cp[7:0];
                        return 1;
                    end
                    for (int i = 0; i < 32; i++) begin
                        if ({16'd0, CP1252_HI[i]} == cp) begin
                            b[0] = 8'h80 + i[7:0];
                            return 1;
                        end
                    end
                    return 0;
                end
                ENC_UCS4: begin
                    b = cp;
                    return 4;
                end
                default: return -1;
            endcase
        endfunction

        function void owe(bit [7:0] by, bit [1:0] k, bit last);
            out_item_t o;
            o.out_byte = by;
            o.kind = k;
            o.last_of_run = last;
            o.substitution_count = count_view();
            owed_items.push_back(o);
        endfunction

        function void take_byte(in_item_t it);
            bit [7:0]        b;
            bit              eob;
            bit              have;
            bit [31:0]       cp;
            bit [31:0]       v;
            int unsigned     len;
            bit              bad;
            bit [1:0]        err;
            bit [3:0][7:0]   bytes;
            int              n;
            b = it.in_byte;
            eob = it.end_of_buffer;
            have = 0;
            cp = 0;
            err = KIND_DATA;
            n = 0;

            if (draining) begin
                if (!eob) return;
                draining = 0;
                owe(8'h00, KIND_DROPPED, 1'b1);
                subst = 0;
                return;
            end

            case (src_enc)
                ENC_UTF8: begin
                    if (seen == 0) begin
                        if (b < 8'h80) begin
                            cp = {24'd0, b};
                            have = 1;
                        end else if ((b & 8'hE0) == 8'hC0) begin
                            want = 2;
                            acc = {27'd0, b[4:0]};
                        end else if ((b & 8'hF0) == 8'hE0) begin
                            want = 3;
                            acc = {28'd0, b[3:0]};
                        end else if ((b & 8'hF8) == 8'hF0) begin
                            want = 4;
                            acc = {29'd0, b[2:0]};
                        end else begin
                            err = KIND_ILLEGAL;
                        end
                        if (!have && err == KIND_DATA) begin
                            seen = 1;
                            bad_cont = 0;
                        end
                    end else begin
                        if ((b & 8'hC0) != 8'h80) bad_cont = 1;
                        acc = (acc << 6) | {26'd0, b[5:0]};
                        seen++;
                        if (seen >= want) begin
                            v = acc;
                            len = want;
                            bad = bad_cont;
                            clear_partial();
                            if (bad) err = KIND_ILLEGAL;
                            else if (len == 2 && v < 32'h80) err = KIND_ILLEGAL;
                            else if (len == 3 && (v < 32'h800 || (v >= 32'hD800 && v <= 32'hDFFF)))
                                err = KIND_ILLEGAL;
                            else if (len == 4 && (v < 32'h10000 || v > 32'h10FFFF))
                                err = KIND_ILLEGAL;
                            else begin
                                cp = v;
                                have = 1;
                            end
                        end
                    end
                end
                ENC_ASCII: begin
                    if (b > 8'h7F) err = KIND_ILLEGAL;
                    else begin
                        cp = {24'd0, b};
                        have = 1;
                    end
                end
                ENC_LATIN1: begin
                    cp = {24'd0, b};
                    have = 1;
                end
                ENC_CP1252: begin
                    cp = (b >= 8'h80 && b <= 8'h9F) ? {16'd0, CP1252_HI[b[4:0]]} : {24'd0, b};
                    have = 1;
                end
                ENC_UCS4: begin
                    acc |= {24'd0, b} << ((seen & 3) * 8);
                    seen++;
                    if (seen >= 4) begin
                        cp = acc;
                        have = 1;
                        clear_partial();
                    end
                end
                default: err = KIND_ILLEGAL;
            endcase

            if (!have && err == KIND_DATA && eob && seen != 0) err = KIND_INCOMPLETE;
            if (err != KIND_DATA) clear_partial();

            if (have) begin
                n = encode_as(tgt_enc, cp, bytes);
                if (n == 0) begin
                    if (translit) begin
                        bytes[0] = QMARK;
                        n = 1;
                        if (subst < CNT_MAX) subst++;
                    end else begin
                        err = KIND_ILLEGAL;
                    end
                end else if (n < 0) begin
                    n = 0;
                    err = KIND_ILLEGAL;
                end
            end

            if (err != KIND_DATA) begin
                owe(8'h00, err, 1'b1);
                if (eob) subst = 0;
                else draining = 1;
                return;
            end
            for (int k = 0; k < n; k++) owe(bytes[k], KIND_DATA, k == n - 1);
            if (eob) subst = 0;
        endfunction

        function void cmp_field(string nm, logic [31:0] e, logic [31:0] a);
            if (a !== e) begin
                $display("%0t: %s expected %0h, actual %0h", $time, nm, e, a);
                fails++;
            end
        endfunction

        function void check_output(out_item_t got);
            out_item_t e;
            if (owed_items.size() == 0) begin
                $display("%0t: no item expected, actual %p", $time, got);
                fails++;
                return;
            end
            e = owed_items.pop_front();
            cmp_field("out_byte", e.out_byte, got.out_byte);
            cmp_field("kind", e.kind, got.kind);
            cmp_field("last_of_run", e.last_of_run, got.last_of_run);
            cmp_field("substitution_count", e.substitution_count, got.substitution_count);
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [2:0] cfg_data;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;

    transcode_tracker sb;
    in_item_t         script[$];
    bit               hold_req;
    bit               calm;

    charset_transcoder #(
        .COUNT_WIDTH(CNT_W)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.take_byte(s_data);
            if (m_valid && m_ready) sb.check_output(m_data);
        end
    end

    // output side stalls, plus one long hold on request
    initial begin
        forever begin
            m_ready <= 1'b1;
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 0;
                m_ready <= 1'b0;
                repeat (60) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end
        end
    end

    function automatic void add(bit [7:0] by, bit eob);
        in_item_t it;
        it.in_byte = by;
        it.end_of_buffer = eob;
        script.push_back(it);
    endfunction

    function automatic bit [31:0] pick_cp();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom_range(0, 'h7F);
            3, 4:    return $urandom_range('h80, 'hFF);
            5:       return $urandom_range('h100, 'h7FF);
            6:       return {16'd0, CP1252_HI[$urandom_range(0, 31)]};
            7:       return $urandom_range('h800, 'hFFFF);
            8:       return $urandom_range('h10000, 'h10FFFF);
            default: return $urandom();
        endcase
    endfunction

    // mostly whole characters of the source encoding, some stray bytes
    function automatic void build_phase(bit [2:0] enc, int count);
        bit [3:0][7:0] b;
        int            n;
        while (script.size() < count) begin
            n = 0;
            if (enc == ENC_UTF8 && $urandom_range(0, 9) != 0) begin
                n = sb.encode_as(ENC_UTF8, pick_cp(), b);
            end else if (enc == ENC_UCS4 && $urandom_range(0, 9) != 0) begin
                b = pick_cp();
                n = 4;
            end
            if (n <= 0) add(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
            else
                for (int k = 0; k < n; k++)
                    add(b[k], $urandom_range(0, (k == n - 1) ? 4 : 29) == 0);
        end
    endfunction

    task automatic send_byte(in_item_t it);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic play();
        foreach (script[i]) send_byte(script[i]);
        script.delete();
        s_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        int guard;
        guard = 0;
        @(posedge aclk);
        while (sb.owed_items.size() != 0 && guard < 5000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [2:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic run_phase(bit [2:0] src, bit [2:0] tgt, bit tl, int count);
        bit [1:0] pad;
        pad = 2'($urandom_range(0, 3));
        cfg_write(CFG_SOURCE, src);
        cfg_write(CFG_TARGET, tgt);
        cfg_write(CFG_TRANSLIT, {pad, tl});
        cfg_write(CFG_SPARE, 3'($urandom_range(0, 7)));
        cfg_we <= 1'b0;
        build_phase(src, count);
        play();
        wait_drain();
    endtask

    initial begin
        sb = new();
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_data <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // utf-8 to utf-8 corner cases under reset settings
        add(8'h00, 0); add(8'h7F, 1);
        add(8'hC3, 0); add(8'hA9, 0);
        add(8'hE2, 0); add(8'h82, 0); add(8'hAC, 0);
        add(8'hF4, 0); add(8'h8F, 0); add(8'hBF, 0); add(8'hBF, 1);
        // overlong, then dropped up to the end mark
        add(8'hC0, 0); add(8'hAF, 0); add(8'h41, 1);
        // surrogate ending on the end mark
        add(8'hED, 0); add(8'hA0, 0); add(8'h80, 1);
        // above the code space
        add(8'hF4, 0); add(8'h90, 0); add(8'h80, 0); add(8'h80, 1);
        add(8'hFF, 1);
        // bad continuation cut off by the end mark
        add(8'hE2, 0); add(8'h41, 1);
        // bad continuation at full length, then drop
        add(8'hC3, 0); add(8'h41, 0); add(8'h80, 1);
        play();
        wait_drain();

        run_phase(ENC_UCS4, ENC_UTF8, 1, 8);
        hold_req = 1;
        run_phase(ENC_UTF8, ENC_UCS4, 0, 16);
        run_phase(ENC_CP1252, ENC_CP1252, 0, 6);
        run_phase(ENC_LATIN1, ENC_ASCII, 1, 6);
        run_phase(ENC_ASCII, ENC_LATIN1, 0, 6);
        run_phase(ENC_UNKNOWN, ENC_UTF8, 0, 4);
        run_phase(ENC_UTF8, ENC_UNKNOWN, 1, 6);
        run_phase(ENC_UCS4, ENC_CP1252, 1, 8);
        repeat (2) run_phase(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                             1'($urandom_range(0, 1)), 6);
        calm = 1;
        run_phase(ENC_UTF8, ENC_UTF8, 1, 6);
        run_phase(ENC_CP1252, ENC_UCS4, 0, 6);

        wait_drain();
        if (sb.owed_items.size() != 0) begin
            $display("%0t: expected %p, actual none", $time, sb.owed_items[0]);
            sb.fails++;
        end
        if (sb.fails == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
